// File: rtl/cfu_pkg.sv
// Shared constants, types and arithmetic helpers of the camera frame update unit.
package cfu_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_ITERATIONS);
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [3:0] REQ_QUERY      = 4'd0;
    localparam logic [3:0] REQ_MOVE_FWD   = 4'd1;
    localparam logic [3:0] REQ_MOVE_UP    = 4'd2;
    localparam logic [3:0] REQ_MOVE_RIGHT = 4'd3;
    localparam logic [3:0] REQ_FP_RIGHT   = 4'd4;
    localparam logic [3:0] REQ_FP_UP      = 4'd5;
    localparam logic [3:0] REQ_FP_FWD     = 4'd6;
    localparam logic [3:0] REQ_TP_RIGHT   = 4'd7;
    localparam logic [3:0] REQ_TP_UP      = 4'd8;
    localparam logic [3:0] REQ_TP_FWD     = 4'd9;

    localparam logic [1:0] AXIS_RIGHT = 2'd0;
    localparam logic [1:0] AXIS_UP    = 2'd1;
    localparam logic [1:0] AXIS_FWD   = 2'd2;

    typedef logic signed [31:0] word_t;
    typedef word_t vec3_t [3];

    function automatic word_t sat32(input logic signed [63:0] v);
        word_t r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd536870912;
        return t[63:30];
    endfunction

    function automatic logic signed [33:0] cordic_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [33:0] r;
        case (idx)
            5'd0:  r = 34'sh020000000;
            5'd1:  r = 34'sh012E4051E;
            5'd2:  r = 34'sh009FB385B;
            5'd3:  r = 34'sh0051111D4;
            5'd4:  r = 34'sh0028B0D43;
            5'd5:  r = 34'sh00145D7E1;
            5'd6:  r = 34'sh000A2F61E;
            5'd7:  r = 34'sh000517C55;
            5'd8:  r = 34'sh00028BE53;
            5'd9:  r = 34'sh000145F2F;
            5'd10: r = 34'sh0000A2F98;
            5'd11: r = 34'sh0000517CC;
            5'd12: r = 34'sh000028BE6;
            5'd13: r = 34'sh0000145F3;
            5'd14: r = 34'sh00000A2FA;
            5'd15: r = 34'sh00000517D;
            5'd16: r = 34'sh0000028BE;
            5'd17: r = 34'sh00000145F;
            5'd18: r = 34'sh000000A30;
            5'd19: r = 34'sh000000518;
            5'd20: r = 34'sh00000028C;
            5'd21: r = 34'sh000000146;
            5'd22: r = 34'sh0000000A3;
            5'd23: r = 34'sh000000051;
            5'd24: r = 34'sh000000029;
            5'd25: r = 34'sh000000014;
            5'd26: r = 34'sh00000000A;
            5'd27: r = 34'sh000000005;
            5'd28: r = 34'sh000000003;
            5'd29: r = 34'sh000000001;
            default: r = 34'sh000000000;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/cfu_req_if.sv
// Request channel interface of the camera frame update unit.
interface cfu_req_if;
    logic              valid;
    logic              ready;
    logic [3:0]        req_type;
    logic signed [31:0] distance;
    logic signed [15:0] angle;
    logic signed [31:0] pivot_distance;

    modport source (output valid, output req_type, output distance, output angle,
                    output pivot_distance, input ready);
    modport sink (input valid, input req_type, input distance, input angle,
                  input pivot_distance, output ready);
endinterface

// File: rtl/cfu_rsp_if.sv
// Response channel interface of the camera frame update unit.
interface cfu_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;

    modport source (output valid, output eye_x, output eye_y, output eye_z,
                    output center_x, output center_y, output center_z,
                    output up_x, output up_y, output up_z, input ready);
    modport sink (input valid, input eye_x, input eye_y, input eye_z,
                  input center_x, input center_y, input center_z,
                  input up_x, input up_y, input up_z, output ready);
endinterface

// File: rtl/camera_frame_update_unit.sv
// Camera frame update unit: sequencer, frame state and shared multiplier.
//
// Requests arrive on the req channel (valid/ready); each accepted transaction
// produces exactly one transaction on the rsp channel with eye, center and up
// after the update. The unit works on one request at a time and holds req.ready
// low until its result has been loaded into the output register.
// Each request is worked through the single 32x32 multiplier and the iterative
// CORDIC, square root and divider units, as its type requires:
//   query or unused code: straight to the output register
//   move: the scaled axis added to the position, one component at a time
//   first-person turn: CORDIC, then rotation of the two other axes
//   third-person turn: first-person steps, then pivot, square sum, square root, divide
// A zero-length turned axis skips the divide steps.
// The output register frees req.ready as soon as the result is loaded, so the
// next request runs while a result waits; a stalled receiver holds rsp steady
// and blocks only the loading of the following result.
// Reset sets position to zero and the frame to forward (0,0,1), up (0,1,0),
// right (1,0,0), and clears rsp.valid.
module camera_frame_update_unit
    import cfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cfu_req_if.sink     req,
    cfu_rsp_if.source   rsp
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CORDIC = 9'b000000010,
        S_MOVE   = 9'b000000100,
        S_TURN   = 9'b000001000,
        S_PIVOT  = 9'b000010000,
        S_SQSUM  = 9'b000100000,
        S_SQRT   = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] k_reg, k_next;

    vec3_t pos_reg, pos_next, fwd_reg, fwd_next, up_reg, up_next;
    vec3_t right_reg, right_next, olda_reg, olda_next;

    logic [3:0] code_reg, code_next;
    logic [1:0] axis_reg, axis_next;
    logic       third_reg, third_next;
    word_t      dist_reg, dist_next, pd_reg, pd_next;

    logic signed [35:0] acc_reg, acc_next, ta_reg, ta_next;
    logic [63:0]        sq_reg, sq_next;
    logic signed [63:0] prod_reg;
    word_t              mul_a, mul_b;
    logic signed [33:0] rnd;

    logic  cordic_start, cordic_busy;
    word_t cos_val, sin_val;
    logic  sqrt_start, sqrt_busy;
    logic [31:0] root;
    logic  div_start, div_busy;
    logic [61:0] dividend, quotient;

    word_t a_cur, b_cur, mv_cur, sat_a, sat_b, q_word;
    logic [31:0] mag_abs;

    logic  out_valid_reg, out_valid_next;
    vec3_t eye_reg, eye_next, ctr_reg, ctr_next, upo_reg, upo_next;
    vec3_t ctr_calc;
    logic  in_accept;

    cfu_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (req.angle),
        .busy    (cordic_busy),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    cfu_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    cfu_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (root),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign in_accept = req.valid && (state_reg == S_IDLE);

    assign a_cur  = (axis_reg == AXIS_FWD) ? up_reg[k_reg] : fwd_reg[k_reg];
    assign b_cur  = (axis_reg == AXIS_RIGHT) ? up_reg[k_reg] : right_reg[k_reg];
    assign mv_cur = (code_reg == REQ_MOVE_FWD) ? fwd_reg[k_reg]
                  : ((code_reg == REQ_MOVE_UP) ? up_reg[k_reg] : right_reg[k_reg]);

    assign rnd     = rnd30(prod_reg);
    assign sat_a   = sat32(64'(ta_reg));
    assign sat_b   = sat32(64'(acc_reg - 36'(rnd)));
    assign mag_abs = a_cur[31] ? 32'(-a_cur) : 32'(a_cur);
    assign dividend = {mag_abs, 30'h0} + 62'(root >> 1);

    always_comb
    begin
        if (a_cur[31])
        begin
            q_word = (quotient > 62'd2147483648) ? 32'sh80000000 : 32'(-quotient);
        end
        else
        begin
            q_word = (quotient > 62'd2147483647) ? 32'sh7FFFFFFF : 32'(quotient);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MOVE:
            begin
                mul_a = mv_cur;
                mul_b = dist_reg;
            end
            S_TURN:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = a_cur;
                        mul_b = cos_val;
                    end
                    3'd1:
                    begin
                        mul_a = b_cur;
                        mul_b = sin_val;
                    end
                    3'd2:
                    begin
                        mul_a = b_cur;
                        mul_b = cos_val;
                    end
                    default:
                    begin
                        mul_a = a_cur;
                        mul_b = sin_val;
                    end
                endcase
            end
            S_PIVOT:
            begin
                mul_a = (step_reg == 3'd0) ? olda_reg[k_reg] : a_cur;
                mul_b = pd_reg;
            end
            S_SQSUM:
            begin
                mul_a = a_cur;
                mul_b = a_cur;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ctr_calc[i] = sat32(64'(pos_reg[i])
                                + 64'(19'((33'(fwd_reg[i]) + 33'sd8192) >>> 14)));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        fwd_next       = fwd_reg;
        up_next        = up_reg;
        right_next     = right_reg;
        olda_next      = olda_reg;
        code_next      = code_reg;
        axis_next      = axis_reg;
        third_next     = third_reg;
        dist_next      = dist_reg;
        pd_next        = pd_reg;
        acc_next       = acc_reg;
        ta_next        = ta_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg;
        eye_next       = eye_reg;
        ctr_next       = ctr_reg;
        upo_next       = upo_reg;
        cordic_start   = 1'b0;
        sqrt_start     = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    code_next = req.req_type;
                    dist_next = req.distance;
                    pd_next   = req.pivot_distance;
                    k_next    = '0;
                    step_next = '0;
                    case (req.req_type)
                        REQ_MOVE_FWD, REQ_MOVE_UP, REQ_MOVE_RIGHT:
                        begin
                            state_next = S_MOVE;
                        end
                        REQ_FP_RIGHT, REQ_TP_RIGHT:
                        begin
                            axis_next    = AXIS_RIGHT;
                            third_next   = (req.req_type == REQ_TP_RIGHT);
                            cordic_start = 1'b1;
                            state_next   = S_CORDIC;
                        end
                        REQ_FP_UP, REQ_TP_UP:
                        begin
                            axis_next    = AXIS_UP;
                            third_next   = (req.req_type == REQ_TP_UP);
                            cordic_start = 1'b1;
                            state_next   = S_CORDIC;
                        end
                        REQ_FP_FWD, REQ_TP_FWD:
                        begin
                            axis_next    = AXIS_FWD;
                            third_next   = (req.req_type == REQ_TP_FWD);
                            cordic_start = 1'b1;
                            state_next   = S_CORDIC;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_CORDIC:
            begin
                if (!cordic_busy)
                begin
                    state_next = S_TURN;
                end
            end
            S_MOVE:
            begin
                if (step_reg == 3'd0)
                begin
                    step_next = 3'd1;
                end
                else
                begin
                    pos_next[k_reg] = sat32(64'(pos_reg[k_reg]) + 64'(rnd));
                    step_next = 3'd0;
                    if (k_reg == 2'd2)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_TURN:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    3'd0:
                    begin
                        olda_next[k_reg] = a_cur;
                    end
                    3'd1:
                    begin
                        acc_next = 36'(rnd);
                    end
                    3'd2:
                    begin
                        ta_next = acc_reg + 36'(rnd);
                    end
                    3'd3:
                    begin
                        acc_next = 36'(rnd);
                    end
                    default:
                    begin
                        if (axis_reg == AXIS_FWD)
                        begin
                            up_next[k_reg] = sat_a;
                        end
                        else
                        begin
                            fwd_next[k_reg] = sat_a;
                        end
                        if (axis_reg == AXIS_RIGHT)
                        begin
                            up_next[k_reg] = sat_b;
                        end
                        else
                        begin
                            right_next[k_reg] = sat_b;
                        end
                        step_next = 3'd0;
                        if (k_reg == 2'd2)
                        begin
                            k_next = 2'd0;
                            state_next = third_reg ? S_PIVOT : S_OUT;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                endcase
            end
            S_PIVOT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd1)
                begin
                    acc_next = 36'(pos_reg[k_reg]) + 36'(rnd);
                end
                else if (step_reg == 3'd2)
                begin
                    pos_next[k_reg] = sat32(64'(acc_reg - 36'(rnd)));
                    step_next = 3'd0;
                    if (k_reg == 2'd2)
                    begin
                        k_next     = 2'd0;
                        sq_next    = '0;
                        state_next = S_SQSUM;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_SQSUM:
            begin
                if (step_reg == 3'd0)
                begin
                    step_next = 3'd1;
                end
                else
                begin
                    sq_next = sq_reg + prod_reg;
                    step_next = 3'd0;
                    if (k_reg == 2'd2)
                    begin
                        k_next     = 2'd0;
                        state_next = S_SQRT;
                        step_next  = 3'd1;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_SQRT:
            begin
                if (step_reg == 3'd1)
                begin
                    sqrt_start = 1'b1;
                    step_next  = 3'd0;
                end
                else if (!sqrt_busy)
                begin
                    state_next = (root == 32'd0) ? S_OUT : S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == 3'd0)
                begin
                    div_start = 1'b1;
                    step_next = 3'd1;
                end
                else if (!div_busy)
                begin
                    if (axis_reg == AXIS_FWD)
                    begin
                        up_next[k_reg] = q_word;
                    end
                    else
                    begin
                        fwd_next[k_reg] = q_word;
                    end
                    step_next = 3'd0;
                    if (k_reg == 2'd2)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    eye_next       = pos_reg;
                    ctr_next       = ctr_calc;
                    upo_next       = up_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            third_reg     <= 1'b0;
            axis_reg      <= AXIS_RIGHT;
            code_reg      <= REQ_QUERY;
            pos_reg       <= '{32'sd0, 32'sd0, 32'sd0};
            fwd_reg       <= '{32'sd0, 32'sd0, ONE_Q30};
            up_reg        <= '{32'sd0, ONE_Q30, 32'sd0};
            right_reg     <= '{ONE_Q30, 32'sd0, 32'sd0};
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            third_reg     <= third_next;
            axis_reg      <= axis_next;
            code_reg      <= code_next;
            pos_reg       <= pos_next;
            fwd_reg       <= fwd_next;
            up_reg        <= up_next;
            right_reg     <= right_next;
        end
    end

    always_ff @(posedge clk)
    begin
        olda_reg <= olda_next;
        dist_reg <= dist_next;
        pd_reg   <= pd_next;
        acc_reg  <= acc_next;
        ta_reg   <= ta_next;
        sq_reg   <= sq_next;
        eye_reg  <= eye_next;
        ctr_reg  <= ctr_next;
        upo_reg  <= upo_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.eye_x    = eye_reg[0];
    assign rsp.eye_y    = eye_reg[1];
    assign rsp.eye_z    = eye_reg[2];
    assign rsp.center_x = ctr_reg[0];
    assign rsp.center_y = ctr_reg[1];
    assign rsp.center_z = ctr_reg[2];
    assign rsp.up_x     = upo_reg[0];
    assign rsp.up_y     = upo_reg[1];
    assign rsp.up_z     = upo_reg[2];

endmodule

// File: rtl/cfu_cordic.sv
// Iterative CORDIC sine and cosine unit, one micro-rotation per cycle.
module cfu_cordic
    import cfu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               busy,
    output word_t              cos_out,
    output word_t              sin_out
);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] z_in, z_fold;
    logic               flip_in, flip_reg;
    logic               busy_reg;
    logic [CORDIC_CNT_W-1:0] cnt_reg;
    logic signed [33:0] atan_val;

    always_comb
    begin
        z_in = {{2{angle[15]}}, angle, 16'h0000};
        z_fold = z_in;
        flip_in = 1'b0;
        if (z_in > 34'sd1073741824)
        begin
            z_fold = z_in - 34'sd2147483648;
            flip_in = 1'b1;
        end
        else if (z_in < -34'sd1073741824)
        begin
            z_fold = z_in + 34'sd2147483648;
            flip_in = 1'b1;
        end
    end

    assign atan_val = cordic_atan(ATAN_IDX_W'(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CORDIC_CNT_W'(CORDIC_ITERATIONS - 1))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= flip_in;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - (y_reg >>> cnt_reg);
                y_reg <= y_reg + (x_reg >>> cnt_reg);
                z_reg <= z_reg - atan_val;
            end
            else
            begin
                x_reg <= x_reg + (y_reg >>> cnt_reg);
                y_reg <= y_reg - (x_reg >>> cnt_reg);
                z_reg <= z_reg + atan_val;
            end
        end
    end

    assign busy    = busy_reg;
    assign cos_out = flip_reg ? 32'(-x_reg) : 32'(x_reg);
    assign sin_out = flip_reg ? 32'(-y_reg) : 32'(y_reg);

endmodule

// File: rtl/cfu_isqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module cfu_isqrt
    import cfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] n_reg, r_reg, bit_reg;
    logic [64:0] trial;
    logic        busy_reg;
    logic [4:0]  cnt_reg;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if ({1'b0, n_reg} >= trial)
            begin
                n_reg <= n_reg - trial[63:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[31:0];

endmodule

// File: rtl/cfu_divider.sv
// Restoring divider, 62-bit dividend by 32-bit divisor, one quotient bit per cycle.
module cfu_divider
    import cfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [61:0] quotient
);

    logic [31:0] rem_reg, den_reg;
    logic [61:0] q_reg;
    logic [32:0] trial;
    logic        busy_reg;
    logic [5:0]  cnt_reg;

    assign trial = {rem_reg, q_reg[61]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd61)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= divisor;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= 32'(trial - {1'b0, den_reg});
                q_reg   <= {q_reg[60:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                q_reg   <= {q_reg[60:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule
